[hw/rtl/assert_macros.svh]
// Assertion helpers for the checker file mhi_checker.sv.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every rising clock edge outside reset.
`define MHI_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("max heap assertion failed");

// Boolean condition must never be seen outside reset.
`define MHI_NEVER(lbl, clk, rst_n, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error("max heap assertion failed");

`endif

[hw/rtl/mhi_pkg.sv]
package mhi_pkg;

    localparam logic OP_INSERT = 1'b0;
    localparam logic OP_FIND   = 1'b1;

    typedef enum logic [2:0] {
        ST_INSERTED = 3'd0,
        ST_FULL     = 3'd1,
        ST_DUP      = 3'd2,
        ST_FOUND    = 3'd3,
        ST_NOTFOUND = 3'd4
    } mhi_status_t;

    typedef struct packed {
        logic               opcode;
        logic signed [31:0] key;
    } mhi_req_t;

    typedef struct packed {
        mhi_status_t status;
        logic [8:0]  entry_count;
    } mhi_rsp_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_START,
        S_SCAN,
        S_SIFT_RD,
        S_SIFT_CMP,
        S_REPLY
    } mhi_state_t;

    // controller -> datapath
    typedef struct packed {
        logic        load_req;
        logic        scan_start;
        logic        scan_step;
        logic        sift_start;
        logic        parent_rd;
        logic        write_parent;
        logic        write_key;
        logic        set_status;
        mhi_status_t status_code;
        logic        rsp_load;
    } mhi_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic op_insert;
        logic full;
        logic hit;
        logic scan_done;
        logic at_root;
        logic parent_less;
        logic out_free;
    } mhi_sts_t;

endpackage

[hw/rtl/mhi_ctrl.sv]
module mhi_ctrl
    import mhi_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     req_valid,
    output logic     req_stall,
    input  mhi_sts_t sts,
    output mhi_cmd_t cmd
);

    mhi_state_t state_reg;
    mhi_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        req_stall  = (state_reg != S_IDLE);
        unique case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    cmd.load_req = 1'b1;
                    state_next   = S_START;
                end
            end
            S_START:
            begin
                // full is checked before the duplicate scan
                if (sts.op_insert && sts.full)
                begin
                    cmd.set_status  = 1'b1;
                    cmd.status_code = ST_FULL;
                    state_next      = S_REPLY;
                end
                else
                begin
                    cmd.scan_start = 1'b1;
                    state_next     = S_SCAN;
                end
            end
            S_SCAN:
            begin
                cmd.scan_step = 1'b1;
                // keeps scanning while neither a hit nor the end is seen
                if (sts.hit)
                begin
                    cmd.set_status  = 1'b1;
                    cmd.status_code = sts.op_insert ? ST_DUP : ST_FOUND;
                    state_next      = S_REPLY;
                end
                else if (sts.scan_done)
                begin
                    if (sts.op_insert)
                    begin
                        cmd.sift_start = 1'b1;
                        state_next     = S_SIFT_RD;
                    end
                    else
                    begin
                        cmd.set_status  = 1'b1;
                        cmd.status_code = ST_NOTFOUND;
                        state_next      = S_REPLY;
                    end
                end
            end
            S_SIFT_RD:
            begin
                if (sts.at_root)
                begin
                    cmd.write_key   = 1'b1;
                    cmd.set_status  = 1'b1;
                    cmd.status_code = ST_INSERTED;
                    state_next      = S_REPLY;
                end
                else
                begin
                    cmd.parent_rd = 1'b1;
                    state_next    = S_SIFT_CMP;
                end
            end
            S_SIFT_CMP:
            begin
                if (sts.parent_less)
                begin
                    cmd.write_parent = 1'b1;
                    state_next       = S_SIFT_RD;
                end
                else
                begin
                    cmd.write_key   = 1'b1;
                    cmd.set_status  = 1'b1;
                    cmd.status_code = ST_INSERTED;
                    state_next      = S_REPLY;
                end
            end
            S_REPLY:
            begin
                if (sts.out_free)
                begin
                    cmd.rsp_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

[hw/rtl/mhi_dpath.sv]
module mhi_dpath
    import mhi_pkg::*;
#(
    parameter int DEPTH = 256
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cap_wr_en,
    input  logic [8:0] cap_wr_data,
    input  mhi_req_t   req,
    input  mhi_cmd_t   cmd,
    output mhi_sts_t   sts,
    output mhi_rsp_t   rsp,
    output logic       rsp_valid,
    input  logic       rsp_stall
);

    localparam int CW   = $clog2(DEPTH + 1);
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CMPW = (CW > 9) ? CW : 9;

    logic signed [31:0] mem [DEPTH];

    logic [8:0]         cap_reg;
    logic [CW-1:0]      count_reg;
    logic [CW-1:0]      count_next;
    logic [CW-1:0]      scan_addr_reg;
    logic [CW-1:0]      scan_addr_next;
    logic               rd_vld_reg;
    logic               rd_vld_next;
    logic               rsp_valid_reg;
    logic               rsp_valid_next;
    logic               op_reg;
    logic signed [31:0] key_reg;
    logic signed [31:0] rd_data_reg;
    logic [CW-1:0]      pos_reg;
    mhi_status_t        stat_reg;
    mhi_rsp_t           rsp_reg;

    logic               scan_more;
    logic [CW-1:0]      parent_pos0;
    logic [CW-1:0]      cur_pos0;
    logic [AW-1:0]      rd_addr;
    logic [AW-1:0]      wr_addr;
    logic               rd_en;
    logic               wr_en;
    logic signed [31:0] wr_data;
    logic [CMPW-1:0]    count_ext;
    logic [CMPW-1:0]    cap_ext;
    logic [CMPW-1:0]    eff_cap;

    assign count_ext = CMPW'(count_reg);
    assign cap_ext   = CMPW'(cap_reg);
    assign eff_cap   = (cap_ext > CMPW'(DEPTH)) ? CMPW'(DEPTH) : cap_ext;

    assign scan_more   = (scan_addr_reg < count_reg);
    assign parent_pos0 = (pos_reg >> 1) - CW'(1);
    assign cur_pos0    = pos_reg - CW'(1);

    assign rd_en   = cmd.parent_rd || (cmd.scan_step && scan_more);
    assign rd_addr = cmd.parent_rd ? parent_pos0[AW-1:0] : scan_addr_reg[AW-1:0];
    assign wr_en   = cmd.write_parent || cmd.write_key;
    assign wr_addr = cur_pos0[AW-1:0];
    assign wr_data = cmd.write_parent ? rd_data_reg : key_reg;

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_comb
    begin
        count_next = count_reg;
        if (cmd.sift_start)
        begin
            count_next = count_reg + CW'(1);
        end

        scan_addr_next = scan_addr_reg;
        rd_vld_next    = rd_vld_reg;
        if (cmd.scan_start)
        begin
            scan_addr_next = '0;
            rd_vld_next    = 1'b0;
        end
        else if (cmd.scan_step)
        begin
            rd_vld_next = scan_more;
            if (scan_more)
            begin
                scan_addr_next = scan_addr_reg + CW'(1);
            end
        end

        rsp_valid_next = rsp_valid_reg;
        if (cmd.rsp_load)
        begin
            rsp_valid_next = 1'b1;
        end
        else if (!rsp_stall)
        begin
            rsp_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cap_reg       <= 9'd256;
            count_reg     <= '0;
            scan_addr_reg <= '0;
            rd_vld_reg    <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            if (cap_wr_en)
            begin
                cap_reg <= cap_wr_data;
            end
            count_reg     <= count_next;
            scan_addr_reg <= scan_addr_next;
            rd_vld_reg    <= rd_vld_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_req)
        begin
            op_reg  <= req.opcode;
            key_reg <= req.key;
        end
        // new key takes slot count+1 and walks toward the root
        if (cmd.sift_start)
        begin
            pos_reg <= count_reg + CW'(1);
        end
        else if (cmd.write_parent)
        begin
            pos_reg <= pos_reg >> 1;
        end
        if (cmd.set_status)
        begin
            stat_reg <= cmd.status_code;
        end
        if (cmd.rsp_load)
        begin
            rsp_reg.status      <= stat_reg;
            rsp_reg.entry_count <= count_ext[8:0];
        end
    end

    always_comb
    begin
        sts.op_insert   = (op_reg == OP_INSERT);
        sts.full        = (count_ext >= eff_cap);
        sts.hit         = rd_vld_reg && (rd_data_reg == key_reg);
        sts.scan_done   = !rd_vld_reg && !scan_more;
        sts.at_root     = (pos_reg == CW'(1));
        sts.parent_less = (rd_data_reg < key_reg);
        sts.out_free    = !rsp_valid_reg || !rsp_stall;
    end

    assign rsp       = rsp_reg;
    assign rsp_valid = rsp_valid_reg;

endmodule

[hw/rtl/max_heap_insert_find.sv]
// Binary max-heap of signed 32-bit keys with insert and find requests, one
// request at a time. Every request but an insert into a full heap scans the
// held keys through the single store read port, one entry per cycle, and
// stops early on a match; an insert that misses then sifts up, each level
// taking a parent read and then a compare and write. The reply sits in an
// output register, so the next request is taken while the previous reply is
// still stalled. Capacity (reset 256, clamped to DEPTH) is to be written by
// the user only while idle; the block itself does not enforce it. Reset
// empties the heap.
module max_heap_insert_find
    import mhi_pkg::*;
#(
    parameter int DEPTH = 256
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       req_valid,
    output logic       req_stall,
    input  mhi_req_t   req,
    output logic       rsp_valid,
    input  logic       rsp_stall,
    output mhi_rsp_t   rsp,
    input  logic       cap_wr_en,
    input  logic [8:0] cap_wr_data
);

    mhi_cmd_t cmd;
    mhi_sts_t sts;

    mhi_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .sts       (sts),
        .cmd       (cmd)
    );

    mhi_dpath #(
        .DEPTH (DEPTH)
    ) u_dpath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cap_wr_en   (cap_wr_en),
        .cap_wr_data (cap_wr_data),
        .req         (req),
        .cmd         (cmd),
        .sts         (sts),
        .rsp         (rsp),
        .rsp_valid   (rsp_valid),
        .rsp_stall   (rsp_stall)
    );

endmodule

[hw/rtl/mhi_checker.sv]
`include "assert_macros.svh"

module mhi_checker
    import mhi_pkg::*;
(
    input logic     clk,
    input logic     rst_n,
    input logic     req_valid,
    input logic     req_stall,
    input logic     rsp_valid,
    input logic     rsp_stall,
    input mhi_rsp_t rsp
);

    `MHI_ASSERT(a_rsp_hold, clk, rst_n, rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))

    // one request in flight: busy right after a request is taken
    `MHI_ASSERT(a_busy_after_req, clk, rst_n, req_valid && !req_stall |=> req_stall)

    // a reply is never loaded in the cycle right after a request is taken
    `MHI_ASSERT(a_no_instant_rsp, clk, rst_n, req_valid && !req_stall |=> !$rose(rsp_valid))

    // a new reply only comes out of a busy block
    `MHI_NEVER(a_rsp_needs_req, clk, rst_n, $rose(rsp_valid) && !$past(req_stall))

endmodule

bind max_heap_insert_find mhi_checker u_mhi_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
);

[tb/max_heap_checker.sv]
`timescale 1ns / 100ps

module max_heap_checker
    import mhi_pkg::*;
#(
    parameter int DEPTH = 256
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       req_valid,
    input  logic       req_stall,
    input  mhi_req_t   req,
    input  logic       rsp_valid,
    input  logic       rsp_stall,
    input  mhi_rsp_t   rsp,
    input  logic       cap_wr_en,
    input  logic [8:0] cap_wr_data,
    output int         fail_count,
    output int         replies_owed
);

    logic signed [31:0] heap_keys [1:DEPTH];
    int unsigned        held;
    logic [8:0]         capacity;
    mhi_rsp_t           replies_due [$];

    // Applies one request to the local heap copy and returns the reply it earns.
    function automatic mhi_rsp_t heap_step(mhi_req_t r);
        mhi_rsp_t    res;
        int unsigned limit;
        int unsigned pos;
        logic        hit;
        hit = 1'b0;
        for (int unsigned i = 1; i <= held; i++)
            if (heap_keys[i] == r.key)
                hit = 1'b1;
        limit = (capacity > DEPTH) ? DEPTH : capacity;
        if (r.opcode == OP_INSERT)
        begin
            // full wins over duplicate
            if (held >= limit)
                res.status = ST_FULL;
            else if (hit)
                res.status = ST_DUP;
            else
            begin
                held++;
                pos = held;
                while (pos > 1 && heap_keys[pos / 2] < r.key)
                begin
                    heap_keys[pos] = heap_keys[pos / 2];
                    pos = pos / 2;
                end
                heap_keys[pos] = r.key;
                res.status = ST_INSERTED;
            end
        end
        else
            res.status = hit ? ST_FOUND : ST_NOTFOUND;
        res.entry_count = held[8:0];
        return res;
    endfunction

    task automatic log_mismatch(string what);
        fail_count++;
        if (fail_count <= 10)
            $display("%0t checker: %s", $time, what);
    endtask

    always @(posedge clk or negedge rst_n)
    begin : watch
        mhi_rsp_t want;
        if (!rst_n)
        begin
            held = 0;
            capacity = 9'd256;
            replies_due.delete();
            fail_count = 0;
            replies_owed = 0;
        end
        else
        begin
            if (cap_wr_en)
                capacity = cap_wr_data;
            // reply side first: a reply accepted now belongs to an older request
            if (rsp_valid && !rsp_stall)
            begin
                if (replies_due.size() == 0)
                    log_mismatch($sformatf("reply with no request pending: status=%0d count=%0d",
                                           int'(rsp.status), rsp.entry_count));
                else
                begin
                    want = replies_due.pop_front();
                    if (rsp.status !== want.status || rsp.entry_count !== want.entry_count)
                        log_mismatch($sformatf(
                            "reply mismatch: status exp=%0d got=%0d, entry_count exp=%0d got=%0d",
                            int'(want.status), int'(rsp.status),
                            want.entry_count, rsp.entry_count));
                end
            end
            if (req_valid && !req_stall)
                replies_due.push_back(heap_step(req));
            replies_owed = replies_due.size();
        end
    end

endmodule

[tb/testbench.sv]
`timescale 1ns / 100ps

module testbench;
    import mhi_pkg::*;

    localparam int DEPTH        = 256;
    localparam int CYCLE_LIMIT  = 1_000_000;
    localparam int DRAIN_CYCLES = 300;

    localparam logic signed [31:0] KEY_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [31:0] KEY_MIN = 32'sh8000_0000;

    logic       clk = 1'b0;
    logic       rst_n;
    logic       req_valid;
    logic       req_stall;
    mhi_req_t   req;
    logic       rsp_valid;
    logic       rsp_stall;
    mhi_rsp_t   rsp;
    logic       cap_wr_en;
    logic [8:0] cap_wr_data;
    int         fail_count;
    int         replies_owed;

    // chance (percent) of an idle burst: per request for gaps, per negedge poll for stalls
    int gap_pct   = 0;
    int stall_pct = 0;

    logic signed [31:0] used_keys [$];

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    max_heap_insert_find #(.DEPTH(DEPTH)) u_top (
        .clk         (clk),
        .rst_n       (rst_n),
        .req_valid   (req_valid),
        .req_stall   (req_stall),
        .req         (req),
        .rsp_valid   (rsp_valid),
        .rsp_stall   (rsp_stall),
        .rsp         (rsp),
        .cap_wr_en   (cap_wr_en),
        .cap_wr_data (cap_wr_data)
    );

    max_heap_checker #(.DEPTH(DEPTH)) u_checker (
        .clk          (clk),
        .rst_n        (rst_n),
        .req_valid    (req_valid),
        .req_stall    (req_stall),
        .req          (req),
        .rsp_valid    (rsp_valid),
        .rsp_stall    (rsp_stall),
        .rsp          (rsp),
        .cap_wr_en    (cap_wr_en),
        .cap_wr_data  (cap_wr_data),
        .fail_count   (fail_count),
        .replies_owed (replies_owed)
    );

    // Mostly fresh random keys; some repeats, small values and extremes to hit
    // duplicates and finds.
    function automatic logic signed [31:0] pick_key();
        int unsigned sel;
        sel = $urandom_range(0, 9);
        if (sel < 3 && used_keys.size() != 0)
            return used_keys[$urandom_range(0, used_keys.size() - 1)];
        if (sel == 3)
            return $urandom_range(0, 16) - 8;
        if (sel == 4)
        begin
            case ($urandom_range(0, 3))
                0: return KEY_MAX;
                1: return KEY_MIN;
                2: return 32'sd0;
                default: return -32'sd1;
            endcase
        end
        return $urandom();
    endfunction

    task automatic issue(logic op, logic signed [31:0] k);
        mhi_req_t r;
        r.opcode = op;
        r.key = k;
        @(negedge clk);
        if (gap_pct != 0 && $urandom_range(1, 100) <= gap_pct)
        begin
            req_valid <= 1'b0;
            repeat ($urandom_range(1, 18)) @(negedge clk);
        end
        req_valid <= 1'b1;
        req <= r;
        @(posedge clk);
        while (req_stall)
            @(posedge clk);
        if (op == OP_INSERT)
            used_keys.push_back(k);
    endtask

    task automatic drain();
        @(negedge clk);
        req_valid <= 1'b0;
        while (replies_owed != 0)
            @(negedge clk);
    endtask

    task automatic write_capacity(logic [8:0] v);
        @(negedge clk);
        cap_wr_en <= 1'b1;
        cap_wr_data <= v;
        @(negedge clk);
        cap_wr_en <= 1'b0;
    endtask

    task automatic run_random(int n, int insert_pct);
        logic op;
        for (int i = 0; i < n; i++)
        begin
            op = ($urandom_range(1, 100) <= insert_pct) ? OP_INSERT : OP_FIND;
            issue(op, pick_key());
        end
    endtask

    // reply-side back-pressure
    initial
    begin
        rsp_stall = 1'b0;
        forever
        begin
            @(negedge clk);
            if (stall_pct != 0 && $urandom_range(1, 100) <= stall_pct)
            begin
                rsp_stall <= 1'b1;
                repeat ($urandom_range(1, 18)) @(negedge clk);
                rsp_stall <= 1'b0;
            end
        end
    end

    initial
    begin
        repeat (CYCLE_LIMIT) @(posedge clk);
        $display("status: fail");
        $finish;
    end

    initial
    begin
        rst_n = 1'b0;
        req_valid = 1'b0;
        req = '0;
        cap_wr_en = 1'b0;
        cap_wr_data = '0;
        repeat (6) @(negedge clk);
        rst_n <= 1'b1;

        // directed: reset capacity, extremes, root climbs, duplicates, finds
        gap_pct = 25;
        stall_pct = 10;
        issue(OP_FIND, 32'sd0);
        issue(OP_INSERT, 32'sd0);
        issue(OP_INSERT, KEY_MIN);
        issue(OP_INSERT, KEY_MAX);
        issue(OP_INSERT, -32'sd1);
        issue(OP_INSERT, 32'sd1);
        issue(OP_INSERT, 32'sh5555_5555);
        issue(OP_INSERT, 32'shAAAA_AAAA);
        issue(OP_INSERT, KEY_MAX);
        issue(OP_INSERT, KEY_MIN);
        issue(OP_FIND, KEY_MIN);
        issue(OP_FIND, KEY_MAX);
        issue(OP_FIND, 32'sd12345);
        issue(OP_INSERT, 32'sh7FFF_FFFE);
        drain();

        // capacity zero, below the count: inserts are full even for a held key
        write_capacity(9'd0);
        issue(OP_INSERT, 32'sd7);
        issue(OP_INSERT, 32'sd0);
        issue(OP_FIND, 32'sd0);
        drain();
        write_capacity(9'd4);
        issue(OP_INSERT, 32'sd99);
        issue(OP_FIND, -32'sd1);
        drain();

        // above the store depth: saturates
        write_capacity(9'd511);
        issue(OP_INSERT, 32'sd99);
        issue(OP_FIND, 32'sd99);
        drain();

        gap_pct = 40;
        stall_pct = 15;
        run_random(150, 75);
        drain();

        write_capacity(9'($urandom_range(100, 200)));
        gap_pct = 20;
        stall_pct = 5;
        run_random(100, 80);
        drain();

        // last stretch runs without idling
        write_capacity(9'd256);
        gap_pct = 0;
        stall_pct = 0;
        run_random(150, 90);
        drain();

        repeat (DRAIN_CYCLES) @(negedge clk);
        if (fail_count == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

[sim.f]
+incdir+hw/rtl
hw/rtl/mhi_pkg.sv
hw/rtl/mhi_ctrl.sv
hw/rtl/mhi_dpath.sv
hw/rtl/max_heap_insert_find.sv
hw/rtl/mhi_checker.sv
tb/max_heap_checker.sv
tb/testbench.sv
